>>> design/sapa_pkg.sv
// ----------------------------------------------------------------------------
// sapa_pkg: shared types and constants of the subnet address pool allocator
// Command and CSR codes, request/response payloads, control/status bundles.
// ----------------------------------------------------------------------------
package sapa_pkg;

   localparam int POOL_DEPTH  = 256;
   localparam int POOL_BITS   = $clog2(POOL_DEPTH);
   localparam int WORD_BITS   = 32;
   localparam int WORD_COUNT  = POOL_DEPTH / WORD_BITS;
   localparam int WIDX_W      = $clog2(WORD_COUNT);
   localparam int BIT_W       = $clog2(WORD_BITS);
   localparam int COUNT_W     = POOL_BITS + 1;
   localparam int ADDR_W      = 32;
   localparam int PREFIX_W    = 6;
   localparam int MAX_PREFIX  = 32;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 32;

   localparam logic [PREFIX_W-1:0] PREFIX_RESET = PREFIX_W'(24);

   // request commands (code 3 is a no-op)
   localparam logic [1:0] CMD_ALLOC   = 2'd0;
   localparam logic [1:0] CMD_RELEASE = 2'd1;
   localparam logic [1:0] CMD_CHECK   = 2'd2;

   // CSR indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BASE   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PREFIX = 1'b1;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [ADDR_W-1:0] address;
   } sapa_req_type;

   typedef struct packed {
      logic               status;
      logic [ADDR_W-1:0]  granted_address;
      logic               in_subnet;
      logic [COUNT_W-1:0] busy_count;
   } sapa_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_REPLY
   } sapa_state_type;

   // controller -> datapath
   typedef struct packed {
      logic load_req;
      logic exec_step;
      logic load_rsp;
   } sapa_ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic [1:0] cmd;
      logic       found;
      logic       last_word;
   } sapa_stat_type;

   // index of the lowest set bit; 0 when none is set
   function automatic logic [BIT_W-1:0] lowest_one(input logic [WORD_BITS-1:0] bits);
      logic [BIT_W-1:0] idx;
      idx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (bits[i]) begin
            idx = BIT_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

>>> design/sapa_ctrl.sv
// ----------------------------------------------------------------------------
// sapa_ctrl: request sequencer
// Accepts a request, steps the datapath until done, hands off the response.
// ----------------------------------------------------------------------------
module sapa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output sapa_pkg::sapa_ctl_type dp_ctl,
   input  sapa_pkg::sapa_stat_type dp_stat
);
   import sapa_pkg::*;

   sapa_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           slot_free;
   logic           exec_done;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   // allocate keeps scanning until a free bit or the last word in range
   assign exec_done = (dp_stat.cmd != CMD_ALLOC) || dp_stat.found || dp_stat.last_word;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_done) begin
               state_in = ST_REPLY;
            end
         end
         ST_REPLY: begin
            if (slot_free) begin
               state_in = req_valid ? ST_EXEC : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      dp_ctl    = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready       = 1'b1;
            dp_ctl.load_req = req_valid;
         end
         ST_EXEC: begin
            dp_ctl.exec_step = 1'b1;
         end
         ST_REPLY: begin
            if (slot_free) begin
               dp_ctl.load_rsp = 1'b1;
               req_ready       = 1'b1;
               dp_ctl.load_req = req_valid;
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = dp_ctl.load_rsp ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> design/sapa_datapath.sv
// ----------------------------------------------------------------------------
// sapa_datapath: busy bitmap, counters, config registers, result registers
// Bitmap held as 32-bit words, one word read and written per step.
// ----------------------------------------------------------------------------
module sapa_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  sapa_pkg::sapa_req_type              req_data,
   output sapa_pkg::sapa_rsp_type              rsp_data,
   input  logic                                csr_write_enable,
   input  logic [sapa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sapa_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  sapa_pkg::sapa_ctl_type              dp_ctl,
   output sapa_pkg::sapa_stat_type             dp_stat
);
   import sapa_pkg::*;

   // configuration
   logic [ADDR_W-1:0]    base_ff;
   logic [PREFIX_W-1:0]  prefix_ff;

   // state
   logic [WORD_BITS-1:0] busy_ff [WORD_COUNT];
   logic [COUNT_W-1:0]   used_ff, used_in;

   // current request
   logic [1:0]           cmd_ff;
   logic [ADDR_W-1:0]    addr_ff;
   logic [WIDX_W-1:0]    scan_ff, scan_in;

   // result staging and output register
   sapa_rsp_type         res_ff, res_in;
   sapa_rsp_type         rsp_ff;

   // derived subnet parameters
   logic [PREFIX_W-1:0]  prefix_c;
   logic [PREFIX_W-1:0]  host_bits;
   logic [ADDR_W-1:0]    subnet_mask;
   logic [ADDR_W-1:0]    base_c;
   logic [COUNT_W-1:0]   limit;
   logic [COUNT_W-1:0]   limit_m1;
   logic [WIDX_W-1:0]    last_widx;
   logic [WORD_BITS-1:0] word_valid;

   // step logic
   logic [ADDR_W-1:0]    offset;
   logic                 in_range;
   logic [WIDX_W-1:0]    word_idx;
   logic [WORD_BITS-1:0] rd_word;
   logic [WORD_BITS-1:0] free_bits;
   logic                 found;
   logic [BIT_W-1:0]     free_bit;
   logic                 rel_hit;
   logic                 busy_we;
   logic [WORD_BITS-1:0] busy_word_in;

   assign prefix_c    = (prefix_ff > PREFIX_W'(MAX_PREFIX)) ? PREFIX_W'(MAX_PREFIX) : prefix_ff;
   assign host_bits   = PREFIX_W'(MAX_PREFIX) - prefix_c;
   assign subnet_mask = (prefix_c == '0) ? '0 : ({ADDR_W{1'b1}} << host_bits);
   assign base_c      = base_ff & subnet_mask;
   assign limit       = (host_bits >= PREFIX_W'(POOL_BITS)) ? COUNT_W'(POOL_DEPTH)
                                                            : (COUNT_W'(1) << host_bits);
   assign limit_m1    = limit - COUNT_W'(1);
   assign last_widx   = limit_m1[POOL_BITS-1:BIT_W];
   // limit is a power of two: only a limit below one word leaves a partial word
   assign word_valid  = (limit >= COUNT_W'(WORD_BITS)) ? {WORD_BITS{1'b1}}
                      : ((WORD_BITS'(1) << limit[BIT_W-1:0]) - WORD_BITS'(1));

   assign offset   = addr_ff - base_c;
   assign in_range = (offset[ADDR_W-1:COUNT_W] == '0) && (offset[COUNT_W-1:0] < limit);

   assign word_idx  = (cmd_ff == CMD_ALLOC) ? scan_ff : offset[POOL_BITS-1:BIT_W];
   assign rd_word   = busy_ff[word_idx];
   assign free_bits = ~rd_word & word_valid;
   assign found     = |free_bits;
   assign free_bit  = lowest_one(free_bits);
   assign rel_hit   = in_range && rd_word[offset[BIT_W-1:0]];

   always_comb begin
      busy_we      = 1'b0;
      busy_word_in = rd_word;
      used_in      = used_ff;
      res_in       = res_ff;
      scan_in      = scan_ff;
      if (dp_ctl.exec_step) begin
         res_in = '0;
         case (cmd_ff)
            CMD_ALLOC: begin
               scan_in = scan_ff + WIDX_W'(1);
               if (found) begin
                  busy_we                = 1'b1;
                  busy_word_in[free_bit] = 1'b1;
                  used_in                = used_ff + COUNT_W'(1);
                  res_in.granted_address = base_c + ADDR_W'({scan_ff, free_bit});
               end else begin
                  res_in.status = 1'b1;
               end
            end
            CMD_RELEASE: begin
               if (rel_hit) begin
                  busy_we                             = 1'b1;
                  busy_word_in[offset[BIT_W-1:0]]     = 1'b0;
                  used_in                             = used_ff - COUNT_W'(1);
               end
            end
            CMD_CHECK: begin
               res_in.in_subnet = ((addr_ff & subnet_mask) == base_c);
            end
            default: begin
               res_in.status = 1'b0;
            end
         endcase
         res_in.busy_count = used_in;
      end
      if (dp_ctl.load_req) begin
         scan_in = '0;
      end
   end

   assign dp_stat.cmd       = cmd_ff;
   assign dp_stat.found     = found;
   assign dp_stat.last_word = (scan_ff == last_widx);

   // control-side state
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= '0;
         prefix_ff <= PREFIX_RESET;
         used_ff   <= '0;
         for (int w = 0; w < WORD_COUNT; w++) begin
            busy_ff[w] <= '0;
         end
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_BASE:   base_ff   <= csr_write_data[ADDR_W-1:0];
               CSR_PREFIX: prefix_ff <= csr_write_data[PREFIX_W-1:0];
               default:    base_ff   <= base_ff;
            endcase
         end
         used_ff <= used_in;
         if (busy_we) begin
            busy_ff[word_idx] <= busy_word_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      res_ff  <= res_in;
      if (dp_ctl.load_req) begin
         cmd_ff  <= req_data.cmd;
         addr_ff <= req_data.address;
      end
      if (dp_ctl.load_rsp) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

>>> design/subnet_address_pool_allocator_unit.sv
// ----------------------------------------------------------------------------
// subnet_address_pool_allocator_unit: lowest-free IPv4 address pool allocator
// Allocate scans 1..8 words; release and check need a single datapath step.
// Accept: only in idle or reply, once the previous request has executed.
// Reset: synchronous; bitmap, count and config registers (prefix 24) clear at once.
// ----------------------------------------------------------------------------
//
// The pool bitmap lives in flip-flops as 32-bit words. An allocate walks the
// words from offset zero, one word per cycle, and stops at the first word
// with a free bit inside the current limit (min of subnet size and pool
// depth) or at the last word in range (pool full). Release and check take a
// single datapath step. Results go through a staging register into the
// response register, so a pending response does not block the next request
// from being accepted while the old one drains.
//
module subnet_address_pool_allocator_unit (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  sapa_pkg::sapa_req_type          req_data,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output sapa_pkg::sapa_rsp_type          rsp_data,
   // configuration writes
   input  logic                            csr_write_enable,
   input  logic [sapa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sapa_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import sapa_pkg::*;

   sapa_ctl_type  dp_ctl;
   sapa_stat_type dp_stat;

   // sequencer: idle -> exec (1..8 steps) -> reply
   sapa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_ctl    (dp_ctl),
      .dp_stat   (dp_stat)
   );

   // bitmap, counters, config and result registers
   sapa_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_data         (req_data),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .dp_ctl           (dp_ctl),
      .dp_stat          (dp_stat)
   );

endmodule

>>> design/sapa_checker.sv
// ----------------------------------------------------------------------------
// sapa_checker: port-level checks for the allocator
// Observes only the top-level ports; attached by bind.
// ----------------------------------------------------------------------------
module sapa_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input sapa_pkg::sapa_rsp_type          rsp_data
);
   import sapa_pkg::*;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // one request at a time: ready drops right after an accept
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted on consecutive cycles");

   // a full pool grants nothing
   a_full_no_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status |->
         rsp_data.granted_address == '0 && !rsp_data.in_subnet)
      else $error("full response carries a grant");

   // busy count never exceeds pool depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.busy_count <= COUNT_W'(POOL_DEPTH))
      else $error("busy count out of range");

endmodule

bind subnet_address_pool_allocator_unit sapa_checker u_sapa_checker (.*);
